FILE: design/c_operator_number_lexer_top_defines.svh
// Assertion macros for the C operator and number lexer.
// Included by the top level; uses its clock and reset names.
`ifndef C_OPERATOR_NUMBER_LEXER_TOP_DEFINES_SVH
`define C_OPERATOR_NUMBER_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CONLEX_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("c_operator_number_lexer: assertion failed");

// Next-cycle implication, checked outside reset.
`define CONLEX_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("c_operator_number_lexer: assertion failed");

`endif

FILE: design/conlex_pkg.sv
// Shared types, token and operator codes, and character classifiers for the lexer.
// No dependencies; used by conlex_scan, conlex_queue and the top level.
package conlex_pkg;

   // Token kinds.
   localparam logic [1:0] KIND_OPERATOR = 2'd0;
   localparam logic [1:0] KIND_NUMBER   = 2'd1;
   localparam logic [1:0] KIND_END      = 2'd2;
   localparam logic [1:0] KIND_INVALID  = 2'd3;

   // Operator code carried by tokens that are not operators.
   localparam logic [5:0] NO_CODE = 6'd0;

   // Operator codes, longest operators first.
   localparam logic [5:0] OP_SHL_ASSIGN = 6'd0;
   localparam logic [5:0] OP_SHR_ASSIGN = 6'd1;
   localparam logic [5:0] OP_EQ         = 6'd2;
   localparam logic [5:0] OP_NE         = 6'd3;
   localparam logic [5:0] OP_LE         = 6'd4;
   localparam logic [5:0] OP_GE         = 6'd5;
   localparam logic [5:0] OP_ADD_ASSIGN = 6'd6;
   localparam logic [5:0] OP_SUB_ASSIGN = 6'd7;
   localparam logic [5:0] OP_MUL_ASSIGN = 6'd8;
   localparam logic [5:0] OP_DIV_ASSIGN = 6'd9;
   localparam logic [5:0] OP_MOD_ASSIGN = 6'd10;
   localparam logic [5:0] OP_AND_ASSIGN = 6'd11;
   localparam logic [5:0] OP_XOR_ASSIGN = 6'd12;
   localparam logic [5:0] OP_OR_ASSIGN  = 6'd13;
   localparam logic [5:0] OP_COND       = 6'd14;
   localparam logic [5:0] OP_ARROW      = 6'd15;
   localparam logic [5:0] OP_LOR        = 6'd16;
   localparam logic [5:0] OP_LAND       = 6'd17;
   localparam logic [5:0] OP_SHR        = 6'd18;
   localparam logic [5:0] OP_SHL        = 6'd19;
   localparam logic [5:0] OP_INC        = 6'd20;
   localparam logic [5:0] OP_DEC        = 6'd21;
   localparam logic [5:0] OP_PLUS       = 6'd22;
   localparam logic [5:0] OP_MINUS      = 6'd23;
   localparam logic [5:0] OP_STAR       = 6'd24;
   localparam logic [5:0] OP_SLASH      = 6'd25;
   localparam logic [5:0] OP_PERCENT    = 6'd26;
   localparam logic [5:0] OP_LPAREN     = 6'd27;
   localparam logic [5:0] OP_RPAREN     = 6'd28;
   localparam logic [5:0] OP_LT         = 6'd29;
   localparam logic [5:0] OP_GT         = 6'd30;
   localparam logic [5:0] OP_ASSIGN     = 6'd31;
   localparam logic [5:0] OP_COMMA      = 6'd32;
   localparam logic [5:0] OP_AMP        = 6'd33;
   localparam logic [5:0] OP_CARET      = 6'd34;
   localparam logic [5:0] OP_PIPE       = 6'd35;
   localparam logic [5:0] OP_BANG       = 6'd36;
   localparam logic [5:0] OP_TILDE      = 6'd37;
   localparam logic [5:0] OP_DOT        = 6'd38;
   localparam logic [5:0] OP_LBRACKET   = 6'd39;
   localparam logic [5:0] OP_RBRACKET   = 6'd40;

   // Control characters that count as blanks: tab through carriage return.
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR  = 8'h0D;

   // Result queue geometry. The depth is a power of two so the pointers wrap freely.
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;
   localparam logic [QUEUE_COUNT_BITS-1:0] QUEUE_ROOM_LIMIT = 3'd2;
   localparam logic [QUEUE_COUNT_BITS-1:0] QUEUE_FULL       = 3'd4;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic                        room;
      logic                        nonempty;
      logic [QUEUE_COUNT_BITS-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] code;
   } op_hit_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == " ") || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // True for characters that begin some operator of two or more characters.
   function automatic logic starts_longer(input logic [7:0] c);
      logic r;
      unique case (c) inside
         "=", "!", "<", ">", "+", "-", "*", "/", "%", "&", "^", "|", "?": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic op_hit_type single_op(input logic [7:0] c);
      op_hit_type r;
      r.hit  = 1'b1;
      r.code = NO_CODE;
      unique case (c)
         "+": r.code = OP_PLUS;
         "-": r.code = OP_MINUS;
         "*": r.code = OP_STAR;
         "/": r.code = OP_SLASH;
         "%": r.code = OP_PERCENT;
         "(": r.code = OP_LPAREN;
         ")": r.code = OP_RPAREN;
         "<": r.code = OP_LT;
         ">": r.code = OP_GT;
         "=": r.code = OP_ASSIGN;
         ",": r.code = OP_COMMA;
         "&": r.code = OP_AMP;
         "^": r.code = OP_CARET;
         "|": r.code = OP_PIPE;
         "!": r.code = OP_BANG;
         "~": r.code = OP_TILDE;
         ".": r.code = OP_DOT;
         "[": r.code = OP_LBRACKET;
         "]": r.code = OP_RBRACKET;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic op_hit_type pair_op(input logic [7:0] c0, input logic [7:0] c1);
      op_hit_type r;
      r.hit  = 1'b1;
      r.code = NO_CODE;
      unique case ({c0, c1})
         "==": r.code = OP_EQ;
         "!=": r.code = OP_NE;
         "<=": r.code = OP_LE;
         ">=": r.code = OP_GE;
         "+=": r.code = OP_ADD_ASSIGN;
         "-=": r.code = OP_SUB_ASSIGN;
         "*=": r.code = OP_MUL_ASSIGN;
         "/=": r.code = OP_DIV_ASSIGN;
         "%=": r.code = OP_MOD_ASSIGN;
         "&=": r.code = OP_AND_ASSIGN;
         "^=": r.code = OP_XOR_ASSIGN;
         "|=": r.code = OP_OR_ASSIGN;
         "?:": r.code = OP_COND;
         "->": r.code = OP_ARROW;
         "||": r.code = OP_LOR;
         "&&": r.code = OP_LAND;
         ">>": r.code = OP_SHR;
         "<<": r.code = OP_SHL;
         "++": r.code = OP_INC;
         "--": r.code = OP_DEC;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/c_operator_number_lexer_top.sv
// C operator and number lexer: one source byte per item, zero to two tokens out.
// An accepted item waits in the input register until the queue has room; the scan then
// writes its tokens into the queue together, and the queue offers them one at a time.
// Throughput: one item per cycle, set by the single-pass scan between the input register
// and a four-entry result queue; the input stalls while the queue has room for fewer than two.
// Reset (synchronous, active high) clears the scanner, the byte offset and the queue.
`include "c_operator_number_lexer_top_defines.svh"

module c_operator_number_lexer_top
   import conlex_pkg::*;
#(
   parameter int POSITION_BITS = 16,
   parameter int VALUE_BITS    = 32
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_char_byte,
   input  logic                     req_end_marker,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_token_kind,
   output logic [5:0]               rsp_operator_code,
   output logic [VALUE_BITS-2:0]    rsp_number_value,
   output logic                     rsp_value_overflow,
   output logic [POSITION_BITS-1:0] rsp_start_position,
   output logic [POSITION_BITS-1:0] rsp_token_length,
   output logic                     rsp_last_of_run
);

   // A token travels through the queue as one word. From the low end: length, start
   // position, overflow flag, value, operator code, kind and the last-of-run flag.
   // The scanner packs the word in the same order.
   localparam int WORD_BITS = 2 * POSITION_BITS + VALUE_BITS + 9;
   localparam int START_LO  = POSITION_BITS;
   localparam int OVF_BIT   = 2 * POSITION_BITS;
   localparam int VALUE_LO  = 2 * POSITION_BITS + 1;
   localparam int CODE_LO   = 2 * POSITION_BITS + VALUE_BITS;
   localparam int KIND_LO   = CODE_LO + 6;
   localparam int LAST_BIT  = KIND_LO + 2;

   // The input register holds one accepted item until the queue can take its tokens.
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_char_ff, in_char_in;
   logic                 in_end_ff, in_end_in;

   logic                 req_take;
   logic                 step;
   push_type             push;
   logic [WORD_BITS-1:0] word_a, word_b, word_out;
   queue_status_type     q_status;

   // The scan may emit two tokens, so an item only moves on when two slots are free.
   assign step      = in_valid_ff && q_status.room;
   assign req_stall = in_valid_ff && !q_status.room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_end_in   = in_end_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_char_byte;
         in_end_in   = req_end_marker;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload of the input register needs no reset; it is qualified by in_valid_ff.
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_end_ff  <= in_end_in;
   end

   conlex_scan #(
      .POSITION_BITS (POSITION_BITS),
      .VALUE_BITS    (VALUE_BITS),
      .WORD_BITS     (WORD_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .char_byte  (in_char_ff),
      .end_marker (in_end_ff),
      .push       (push),
      .word_a     (word_a),
      .word_b     (word_b)
   );

   // The queue doubles as the result register; a waiting token never blocks the input
   // side while two slots remain free.
   conlex_queue #(
      .WIDTH (WORD_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .data_a   (word_a),
      .data_b   (word_b),
      .pop      (rsp_valid && !rsp_stall),
      .data_out (word_out),
      .status   (q_status)
   );

   assign rsp_valid          = q_status.nonempty;
   assign rsp_token_length   = word_out[POSITION_BITS-1:0];
   assign rsp_start_position = word_out[START_LO +: POSITION_BITS];
   assign rsp_value_overflow = word_out[OVF_BIT];
   assign rsp_number_value   = word_out[VALUE_LO +: (VALUE_BITS-1)];
   assign rsp_operator_code  = word_out[CODE_LO +: 6];
   assign rsp_token_kind     = word_out[KIND_LO +: 2];
   assign rsp_last_of_run    = word_out[LAST_BIT];

   // The queue must never be pushed beyond its depth.
   `CONLEX_ASSERT_IMP(a_queue_bound, 1'b1, q_status.count <= QUEUE_FULL)
   // The scanner fills the first slot before the second.
   `CONLEX_ASSERT_IMP(a_push_order, push.second, push.first)
   // An end item always yields at least the end token.
   `CONLEX_ASSERT_NEXT(a_end_emits, step && in_end_ff, rsp_valid)
   // An item held back for lack of queue room is kept, not dropped.
   `CONLEX_ASSERT_NEXT(a_held_item, in_valid_ff && !q_status.room, in_valid_ff)

endmodule

FILE: design/conlex_scan.sv
// Scanner state and the single-pass token logic: up to two tokens per byte.
// Depends on conlex_pkg. Token word layout is shared with the top level.
module conlex_scan
   import conlex_pkg::*;
#(
   parameter int POSITION_BITS = 16,
   parameter int VALUE_BITS    = 32,
   parameter int WORD_BITS     = 2 * POSITION_BITS + VALUE_BITS + 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           char_byte,
   input  logic                 end_marker,
   output push_type             push,
   output logic [WORD_BITS-1:0] word_a,
   output logic [WORD_BITS-1:0] word_b
);

   localparam logic [VALUE_BITS-2:0]    VALUE_LIMIT = {(VALUE_BITS-1){1'b1}};
   localparam logic [POSITION_BITS-1:0] ONE_LEN     = {{(POSITION_BITS-1){1'b0}}, 1'b1};

   // Word layout, high to low: last, kind, code, value, overflow, start, length.
   // The last bit is left clear here and set on the way out.
   function automatic logic [WORD_BITS-1:0] pack(
      input logic [1:0]               kind,
      input logic [5:0]               code,
      input logic [VALUE_BITS-2:0]    value,
      input logic                     ovf,
      input logic [POSITION_BITS-1:0] start,
      input logic [POSITION_BITS-1:0] len
   );
      return {1'b0, kind, code, value, ovf, start, len};
   endfunction

   logic [7:0]               pend_char_ff, pend_char_in;
   logic [1:0]               pend_cnt_ff, pend_cnt_in;
   logic [VALUE_BITS-2:0]    acc_ff, acc_in;
   logic                     num_act_ff, num_act_in;
   logic                     sat_ff, sat_in;
   logic [POSITION_BITS-1:0] tok_start_ff, tok_start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     halt_ff, halt_in;

   logic                     c_digit;
   logic [VALUE_BITS+2:0]    acc_times_ten;
   logic                     acc_over;

   logic                     fresh_emit, fresh_num, fresh_pend, fresh_halt;
   op_hit_type               fresh_single;
   logic [WORD_BITS-1:0]     fresh_word;

   logic                     ext_prefix;
   op_hit_type               pair_hit, full_hit, flush_hit;
   logic [1:0]               cnt_plus;
   logic [WORD_BITS-1:0]     num_word, end_word, err_word, full_word, flush_word;

   logic                     take_fresh, fresh_second;
   push_type                 push_raw;
   logic [WORD_BITS-1:0]     raw_a, raw_b;

   assign c_digit = is_digit(char_byte);

   // Multiply by ten and add the digit; the low nibble of an ASCII digit is its value.
   assign acc_times_ten = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                        + {{(VALUE_BITS-1){1'b0}}, char_byte[3:0]};
   assign acc_over      = acc_times_ten > {4'b0000, VALUE_LIMIT};

   // Treatment of a byte that starts fresh, with nothing pending.
   assign fresh_single = single_op(char_byte);
   assign fresh_num    = c_digit;
   assign fresh_pend   = !is_blank(char_byte) && !c_digit && starts_longer(char_byte);
   assign fresh_emit   = !is_blank(char_byte) && !c_digit && !starts_longer(char_byte);
   assign fresh_halt   = fresh_emit && !fresh_single.hit;
   assign fresh_word   = fresh_single.hit
                       ? pack(KIND_OPERATOR, fresh_single.code, '0, 1'b0, pos_ff, ONE_LEN)
                       : pack(KIND_INVALID, NO_CODE, '0, 1'b0, pos_ff, ONE_LEN);

   // Pending operator: extension, full match with this byte, or flush on its own.
   assign ext_prefix = (pend_cnt_ff == 2'd1) && (char_byte == pend_char_ff)
                     && ((pend_char_ff == "<") || (pend_char_ff == ">"));
   assign pair_hit   = pair_op(pend_char_ff, char_byte);
   assign cnt_plus   = pend_cnt_ff + 2'd1;

   always_comb begin
      if (pend_cnt_ff == 2'd1) begin
         full_hit  = pair_hit;
         flush_hit = single_op(pend_char_ff);
      end else begin
         full_hit.hit   = char_byte == "=";
         full_hit.code  = (pend_char_ff == "<") ? OP_SHL_ASSIGN : OP_SHR_ASSIGN;
         flush_hit.hit  = 1'b1;
         flush_hit.code = (pend_char_ff == "<") ? OP_SHL : OP_SHR;
      end
   end

   assign num_word   = pack(KIND_NUMBER, NO_CODE, acc_ff, sat_ff, tok_start_ff,
                            pos_ff - tok_start_ff);
   assign end_word   = pack(KIND_END, NO_CODE, '0, 1'b0, pos_ff, '0);
   assign err_word   = pack(KIND_INVALID, NO_CODE, '0, 1'b0, tok_start_ff, ONE_LEN);
   assign full_word  = pack(KIND_OPERATOR, full_hit.code, '0, 1'b0, tok_start_ff,
                            {{(POSITION_BITS-2){1'b0}}, cnt_plus});
   assign flush_word = pack(KIND_OPERATOR, flush_hit.code, '0, 1'b0, tok_start_ff,
                            {{(POSITION_BITS-2){1'b0}}, pend_cnt_ff});

   always_comb begin
      pend_char_in = pend_char_ff;
      pend_cnt_in  = pend_cnt_ff;
      acc_in       = acc_ff;
      num_act_in   = num_act_ff;
      sat_in       = sat_ff;
      tok_start_in = tok_start_ff;
      pos_in       = pos_ff;
      halt_in      = halt_ff;
      push_raw     = '0;
      raw_a        = '0;
      raw_b        = '0;
      take_fresh   = 1'b0;
      fresh_second = 1'b0;

      if (step) begin
         if (end_marker) begin
            if (!halt_ff && num_act_ff) begin
               push_raw.first = 1'b1;
               raw_a          = num_word;
            end else if (!halt_ff && (pend_cnt_ff != 2'd0)) begin
               push_raw.first = 1'b1;
               raw_a          = flush_hit.hit ? flush_word : err_word;
            end
            if (push_raw.first) begin
               push_raw.second = 1'b1;
               raw_b           = end_word;
            end else begin
               push_raw.first = 1'b1;
               raw_a          = end_word;
            end
            pend_char_in = '0;
            pend_cnt_in  = '0;
            acc_in       = '0;
            num_act_in   = 1'b0;
            sat_in       = 1'b0;
            tok_start_in = '0;
            pos_in       = '0;
            halt_in      = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (halt_ff) begin
               // Bytes are only counted until the end item.
            end else if (num_act_ff) begin
               if (c_digit) begin
                  if (sat_ff || acc_over) begin
                     acc_in = VALUE_LIMIT;
                     sat_in = 1'b1;
                  end else begin
                     acc_in = acc_times_ten[VALUE_BITS-2:0];
                  end
               end else begin
                  push_raw.first = 1'b1;
                  raw_a          = num_word;
                  num_act_in     = 1'b0;
                  take_fresh     = 1'b1;
                  fresh_second   = 1'b1;
               end
            end else if (pend_cnt_ff != 2'd0) begin
               if (ext_prefix) begin
                  pend_cnt_in = 2'd2;
               end else if (full_hit.hit) begin
                  push_raw.first = 1'b1;
                  raw_a          = full_word;
                  pend_cnt_in    = '0;
                  pend_char_in   = '0;
               end else if (flush_hit.hit) begin
                  push_raw.first = 1'b1;
                  raw_a          = flush_word;
                  pend_cnt_in    = '0;
                  pend_char_in   = '0;
                  take_fresh     = 1'b1;
                  fresh_second   = 1'b1;
               end else begin
                  // A question mark without its colon; the byte after it is dropped.
                  push_raw.first = 1'b1;
                  raw_a          = err_word;
                  pend_cnt_in    = '0;
                  pend_char_in   = '0;
                  halt_in        = 1'b1;
               end
            end else begin
               take_fresh = 1'b1;
            end
         end
      end

      if (take_fresh) begin
         if (fresh_num) begin
            num_act_in   = 1'b1;
            sat_in       = 1'b0;
            acc_in       = {{(VALUE_BITS-5){1'b0}}, char_byte[3:0]};
            tok_start_in = pos_ff;
         end
         if (fresh_pend) begin
            pend_char_in = char_byte;
            pend_cnt_in  = 2'd1;
            tok_start_in = pos_ff;
         end
         if (fresh_halt) begin
            halt_in = 1'b1;
         end
         if (fresh_emit) begin
            if (fresh_second) begin
               push_raw.second = 1'b1;
               raw_b           = fresh_word;
            end else begin
               push_raw.first = 1'b1;
               raw_a          = fresh_word;
            end
         end
      end
   end

   assign push   = push_raw;
   assign word_a = {~push_raw.second, raw_a[WORD_BITS-2:0]};
   assign word_b = {1'b1, raw_b[WORD_BITS-2:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_char_ff <= '0;
         pend_cnt_ff  <= '0;
         acc_ff       <= '0;
         num_act_ff   <= 1'b0;
         sat_ff       <= 1'b0;
         tok_start_ff <= '0;
         pos_ff       <= '0;
         halt_ff      <= 1'b0;
      end else begin
         pend_char_ff <= pend_char_in;
         pend_cnt_ff  <= pend_cnt_in;
         acc_ff       <= acc_in;
         num_act_ff   <= num_act_in;
         sat_ff       <= sat_in;
         tok_start_ff <= tok_start_in;
         pos_ff       <= pos_in;
         halt_ff      <= halt_in;
      end
   end

endmodule

FILE: design/conlex_queue.sv
// Result queue: takes up to two token words per cycle, hands out one per cycle while popped.
// Depends on conlex_pkg for its geometry and status struct.
module conlex_queue
   import conlex_pkg::*;
#(
   parameter int WIDTH = 73
) (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic [WIDTH-1:0] data_a,
   input  logic [WIDTH-1:0] data_b,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output queue_status_type status
);

   logic [WIDTH-1:0]            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   head_ff, head_in;
   logic [QUEUE_PTR_BITS-1:0]   tail_ff, tail_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_COUNT_BITS-1:0] push_count;
   logic [QUEUE_PTR_BITS-1:0]   tail_next;

   assign push_count = {{(QUEUE_COUNT_BITS-1){1'b0}}, push.first}
                     + {{(QUEUE_COUNT_BITS-1){1'b0}}, push.second};
   assign tail_next  = tail_ff + 1'b1;
   assign tail_in    = tail_ff + push_count[QUEUE_PTR_BITS-1:0];
   assign head_in    = head_ff + {{(QUEUE_PTR_BITS-1){1'b0}}, pop};
   assign count_in   = count_ff + push_count - {{(QUEUE_COUNT_BITS-1){1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[tail_ff] <= data_a;
      end
      if (push.second) begin
         entry_ff[tail_next] <= data_b;
      end
   end

   assign data_out        = entry_ff[head_ff];
   assign status.room     = count_ff <= QUEUE_ROOM_LIMIT;
   assign status.nonempty = count_ff != '0;
   assign status.count    = count_ff;

endmodule
